// File: sv/tsp_pkg.sv
package tsp_pkg;

   localparam int unsigned TS_LEN = 19;
   localparam int unsigned POS_SAT = 20;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_NONE = 8'h00;

   localparam logic [13:0] YEAR_MIN_RESET = 14'd2000;
   localparam logic [13:0] YEAR_MAX_RESET = 14'd2050;

   // csr register index (byte address bit 2)
   localparam logic CSR_YEAR_MIN = 1'b0;
   localparam logic CSR_YEAR_MAX = 1'b1;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_LEN   = 3'd1,
      ST_SEP   = 3'd2,
      ST_DIGIT = 3'd3,
      ST_RANGE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FLD_YEAR   = 3'd0,
      FLD_MONTH  = 3'd1,
      FLD_DAY    = 3'd2,
      FLD_HOUR   = 3'd3,
      FLD_MINUTE = 3'd4,
      FLD_SECOND = 3'd5
   } field_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } item_type;

   typedef struct packed {
      logic [13:0] year_min;
      logic [13:0] year_max;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } result_type;

   // separator expected at a position, CHAR_NONE for a digit slot
   function automatic logic [7:0] sep_at(input logic [4:0] pos);
      logic [7:0] s;
      unique case (pos)
         5'd4, 5'd7: s = CHAR_SLASH;
         5'd10:      s = CHAR_DASH;
         5'd13, 5'd16: s = CHAR_COLON;
         default:    s = CHAR_NONE;
      endcase
      return s;
   endfunction

   function automatic field_type field_at(input logic [4:0] pos);
      field_type f;
      priority if (pos < 5'd5) f = FLD_YEAR;
      else if (pos < 5'd8) f = FLD_MONTH;
      else if (pos < 5'd11) f = FLD_DAY;
      else if (pos < 5'd14) f = FLD_HOUR;
      else if (pos < 5'd17) f = FLD_MINUTE;
      else f = FLD_SECOND;
      return f;
   endfunction

   function automatic logic [13:0] field_min(input field_type k);
      logic [13:0] v;
      unique case (k)
         FLD_MONTH, FLD_DAY: v = 14'd1;
         default:            v = 14'd0;
      endcase
      return v;
   endfunction

   function automatic logic [13:0] field_max(input field_type k);
      logic [13:0] v;
      unique case (k)
         FLD_MONTH:              v = 14'd12;
         FLD_DAY:                v = 14'd31;
         FLD_HOUR:               v = 14'd23;
         FLD_MINUTE, FLD_SECOND: v = 14'd59;
         default:                v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/tsp_csr.sv
module tsp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output tsp_pkg::cfg_type  cfg
);
   import tsp_pkg::*;

   logic [13:0] year_min_ff;
   logic [13:0] year_max_ff;
   logic [13:0] year_min_in;
   logic [13:0] year_max_in;
   logic        wr_en;
   logic        reg_sel;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[2];

   always_comb begin
      year_min_in = year_min_ff;
      year_max_in = year_max_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_YEAR_MIN: year_min_in = csr_pwdata[13:0];
            CSR_YEAR_MAX: year_max_in = csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_min_ff <= YEAR_MIN_RESET;
         year_max_ff <= YEAR_MAX_RESET;
      end else begin
         year_min_ff <= year_min_in;
         year_max_ff <= year_max_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_YEAR_MIN: csr_prdata = {18'd0, year_min_ff};
         CSR_YEAR_MAX: csr_prdata = {18'd0, year_max_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg.year_min = year_min_ff;
   assign cfg.year_max = year_max_ff;

endmodule

// File: sv/tsp_parse_core.sv
module tsp_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  tsp_pkg::item_type    item,
   input  tsp_pkg::cfg_type     cfg,
   output tsp_pkg::result_type  result
);
   import tsp_pkg::*;

   logic [4:0]  pos_ff;
   logic [13:0] acc_ff;
   logic [13:0] year_ff;
   logic [6:0]  fv_ff [1:5];
   status_type  err_ff;
   logic        bad_ff;

   logic [4:0]  pos_in;
   logic [13:0] acc_in;
   logic [13:0] year_in;
   logic [6:0]  fv_in [1:5];
   status_type  err_in;
   logic        bad_in;

   logic [7:0]  sep;
   field_type   fld;
   logic        is_digit;
   logic [13:0] acc_mul;
   logic [13:0] acc_step;
   logic        bad_step;
   logic        fin;
   logic        sep_ok;
   logic        wr;
   logic [13:0] lo;
   logic [13:0] hi;
   status_type  st;

   assign sep = sep_at(pos_ff);
   assign fld = field_at(pos_ff);
   assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
   // acc * 10 + digit, kept to 14 bits
   assign acc_mul = {acc_ff[10:0], 3'b000} + {acc_ff[12:0], 1'b0}
                    + {10'd0, item.char_code[3:0]};
   assign lo = (fld == FLD_YEAR) ? cfg.year_min : field_min(fld);
   assign hi = (fld == FLD_YEAR) ? cfg.year_max : field_max(fld);

   always_comb begin
      acc_step = acc_ff;
      bad_step = bad_ff;
      fin      = 1'b0;
      sep_ok   = 1'b1;
      if (pos_ff < 5'(TS_LEN)) begin
         if (sep != CHAR_NONE) begin
            fin    = 1'b1;
            sep_ok = (item.char_code == sep);
         end else begin
            if (is_digit) acc_step = acc_mul;
            else bad_step = 1'b1;
            // last field has no separator, close it on its final digit
            if (pos_ff == 5'(TS_LEN - 1)) fin = 1'b1;
         end
      end
   end

   always_comb begin
      err_in = err_ff;
      wr     = 1'b0;
      if (fin && (err_ff == ST_OK)) begin
         priority if (!sep_ok) err_in = ST_SEP;
         else if (bad_step) err_in = ST_DIGIT;
         else if ((acc_step < lo) || (acc_step > hi)) err_in = ST_RANGE;
         else wr = 1'b1;
      end
      acc_in = fin ? 14'd0 : acc_step;
      bad_in = fin ? 1'b0 : bad_step;
      pos_in = (pos_ff < 5'(POS_SAT)) ? pos_ff + 5'd1 : pos_ff;
      year_in = (wr && (fld == FLD_YEAR)) ? acc_step : year_ff;
      for (int i = 1; i <= 5; i++) begin
         fv_in[i] = (wr && (fld == field_type'(i))) ? acc_step[6:0] : fv_ff[i];
      end
   end

   always_comb begin
      st = (pos_in != 5'(TS_LEN)) ? ST_LEN : err_in;
      result.status = st;
      result.year   = (st == ST_OK) ? year_in : 14'd0;
      result.month  = (st == ST_OK) ? fv_in[1] : 7'd0;
      result.day    = (st == ST_OK) ? fv_in[2] : 7'd0;
      result.hour   = (st == ST_OK) ? fv_in[3] : 7'd0;
      result.minute = (st == ST_OK) ? fv_in[4] : 7'd0;
      result.second = (st == ST_OK) ? fv_in[5] : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last_char)) begin
         pos_ff  <= 5'd0;
         acc_ff  <= 14'd0;
         year_ff <= 14'd0;
         for (int i = 1; i <= 5; i++) fv_ff[i] <= 7'd0;
         err_ff  <= ST_OK;
         bad_ff  <= 1'b0;
      end else if (step_en) begin
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
         year_ff <= year_in;
         for (int i = 1; i <= 5; i++) fv_ff[i] <= fv_in[i];
         err_ff  <= err_in;
         bad_ff  <= bad_in;
      end
   end

endmodule

// File: sv/timestamp_text_parser.sv
// path: the last character of a string passes the input register, then the result
//    register, before its result is offered
// throughput: one character per cycle unless a closing character waits for room in the
//    result register; the result register frees the parse stage as soon as a waiting result is taken
// reset (synchronous): parse state cleared, no result pending,
//    year_min = 2000, year_max = 2050
module timestamp_text_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [13:0] rsp_year,
   output logic [6:0]  rsp_month,
   output logic [6:0]  rsp_day,
   output logic [6:0]  rsp_hour,
   output logic [6:0]  rsp_minute,
   output logic [6:0]  rsp_second,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tsp_pkg::*;

   cfg_type    cfg;
   item_type   s1_item_ff;
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_adv;
   result_type core_res;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       req_accept;

   tsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tsp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_adv),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .result  (core_res)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // only the last character needs room in the result register
   assign s1_adv = s1_valid_ff && (!s1_item_ff.last_char || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      if (s1_adv && s1_item_ff.last_char) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.char_code <= req_char_code;
         s1_item_ff.last_char <= req_last_char;
      end
      if (s1_adv && s1_item_ff.last_char) rsp_ff <= core_res;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_year   = rsp_ff.year;
   assign rsp_month  = rsp_ff.month;
   assign rsp_day    = rsp_ff.day;
   assign rsp_hour   = rsp_ff.hour;
   assign rsp_minute = rsp_ff.minute;
   assign rsp_second = rsp_ff.second;

endmodule

// File: sv/tsp_checker.sv
module tsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [13:0] rsp_year,
   input logic [6:0]  rsp_month,
   input logic [6:0]  rsp_day,
   input logic [6:0]  rsp_hour,
   input logic [6:0]  rsp_minute,
   input logic [6:0]  rsp_second
);
   import tsp_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_LEN)
         || (rsp_status == ST_SEP) || (rsp_status == ST_DIGIT)
         || (rsp_status == ST_RANGE))
      else $error("status code out of range");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_year == 14'd0) && (rsp_month == 7'd0) && (rsp_day == 7'd0)
         && (rsp_hour == 7'd0) && (rsp_minute == 7'd0) && (rsp_second == 7'd0))
      else $error("fields not cleared on error");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |->
         (rsp_month >= 7'd1) && (rsp_month <= 7'd12) && (rsp_day >= 7'd1)
         && (rsp_day <= 7'd31) && (rsp_hour <= 7'd23) && (rsp_minute <= 7'd59)
         && (rsp_second <= 7'd59))
      else $error("accepted field out of range");

endmodule

bind timestamp_text_parser tsp_checker u_tsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status),
   .rsp_year   (rsp_year),
   .rsp_month  (rsp_month),
   .rsp_day    (rsp_day),
   .rsp_hour   (rsp_hour),
   .rsp_minute (rsp_minute),
   .rsp_second (rsp_second)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import tsp_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int ROW_COUNT = 26;
   localparam int PHASE_COUNT = 10;
   localparam int STAMPS_PER_PHASE = 6;

   typedef logic [7:0] char_type;
   typedef char_type text_type[$];

   typedef struct {
      string      text;
      bit         typed;
      result_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'd0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [13:0] rsp_year;
   logic [6:0]  rsp_month;
   logic [6:0]  rsp_day;
   logic [6:0]  rsp_hour;
   logic [6:0]  rsp_minute;
   logic [6:0]  rsp_second;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // parser state as the block should hold it
   logic [13:0] cfg_year_min = YEAR_MIN_RESET;
   logic [13:0] cfg_year_max = YEAR_MAX_RESET;
   logic [4:0]  parse_pos = '0;
   logic [13:0] digit_acc = '0;
   logic [13:0] field_val [6] = '{default: '0};
   status_type  first_fault = ST_OK;
   bit          field_junk = 1'b0;

   result_type  pending_stamps[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;
   row_type     rows [ROW_COUNT];
   logic [13:0] phase_lo [5] = '{14'd0, 14'd9999, 14'd0, 14'd3000, 14'd1900};
   logic [13:0] phase_hi [5] = '{14'd9999, 14'd9999, 14'd0, 14'd2000, 14'd1999};

   timestamp_text_parser dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_last_char(req_last_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_year(rsp_year),
      .rsp_month(rsp_month),
      .rsp_day(rsp_day),
      .rsp_hour(rsp_hour),
      .rsp_minute(rsp_minute),
      .rsp_second(rsp_second),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   function automatic result_type failed(input status_type st);
      result_type r;
      r = '{st, 14'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
      return r;
   endfunction

   function automatic string stamp_str(input result_type r);
      return $sformatf("st=%0d %0d/%0d/%0d-%0d:%0d:%0d", r.status, r.year, r.month,
                       r.day, r.hour, r.minute, r.second);
   endfunction

   function automatic void report_miss(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endfunction

   // one character of the timestamp; returns 1 when it closes the string
   function automatic bit parse_char(input char_type c, input logic last,
                                     output result_type stamp);
      char_type   sep;
      field_type  k;
      logic [13:0] lo, hi;
      bit         closing;
      bit         sep_ok;
      status_type st;
      stamp = failed(ST_OK);
      closing = 1'b0;
      sep_ok = 1'b1;
      if (parse_pos < TS_LEN) begin
         case (parse_pos)
            5'd4, 5'd7:   sep = CHAR_SLASH;
            5'd10:        sep = CHAR_DASH;
            5'd13, 5'd16: sep = CHAR_COLON;
            default:      sep = CHAR_NONE;
         endcase
         // every field past the year spans three positions
         k = (parse_pos < 5'd5) ? FLD_YEAR : field_type'((parse_pos - 5'd2) / 5'd3);
         if (sep != CHAR_NONE) begin
            closing = 1'b1;
            sep_ok = (c == sep);
         end else begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
               digit_acc = 14'(digit_acc * 10 + int'(c - CHAR_ZERO));
            else field_junk = 1'b1;
            closing = (parse_pos == TS_LEN - 1);
         end
         if (closing) begin
            case (k)
               FLD_YEAR: begin
                  lo = cfg_year_min;
                  hi = cfg_year_max;
               end
               FLD_MONTH: begin
                  lo = 14'd1;
                  hi = 14'd12;
               end
               FLD_DAY: begin
                  lo = 14'd1;
                  hi = 14'd31;
               end
               FLD_HOUR: begin
                  lo = 14'd0;
                  hi = 14'd23;
               end
               default: begin
                  lo = 14'd0;
                  hi = 14'd59;
               end
            endcase
            if (first_fault == ST_OK) begin
               if (!sep_ok) first_fault = ST_SEP;
               else if (field_junk) first_fault = ST_DIGIT;
               else if (digit_acc < lo || digit_acc > hi) first_fault = ST_RANGE;
               else field_val[k] = digit_acc;
            end
            digit_acc = '0;
            field_junk = 1'b0;
         end
      end
      if (parse_pos < TS_LEN + 1) parse_pos++;
      if (!last) return 1'b0;
      st = (parse_pos != TS_LEN) ? ST_LEN : first_fault;
      if (st == ST_OK) begin
         stamp = '{ST_OK, field_val[FLD_YEAR], field_val[FLD_MONTH][6:0],
                   field_val[FLD_DAY][6:0], field_val[FLD_HOUR][6:0],
                   field_val[FLD_MINUTE][6:0], field_val[FLD_SECOND][6:0]};
      end else begin
         stamp = failed(st);
      end
      parse_pos = '0;
      digit_acc = '0;
      field_val = '{default: '0};
      first_fault = ST_OK;
      field_junk = 1'b0;
      return 1'b1;
   endfunction

   function automatic int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic char_type rand_char();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) begin
         case ($urandom_range(0, 2))
            0: return CHAR_SLASH;
            1: return CHAR_DASH;
            default: return CHAR_COLON;
         endcase
      end
      if (r == 1) return char_type'($urandom_range(CHAR_ZERO, CHAR_NINE));
      return char_type'($urandom_range(1, 255));
   endfunction

   function automatic void push_num(ref text_type q, input int v, input int ndig);
      int div;
      div = 1;
      repeat (ndig - 1) div *= 10;
      repeat (ndig) begin
         q.push_back(CHAR_ZERO + char_type'((v / div) % 10));
         div /= 10;
      end
   endfunction

   // mostly in range, some just outside, some anywhere in two digits
   function automatic int pick_two(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(lo, hi);
      if (r < 85) return (r & 1) ? hi + 1 : ((lo == 0) ? 99 : lo - 1);
      return $urandom_range(0, 99);
   endfunction

   function automatic int pick_year();
      int r;
      int lo;
      int hi;
      r = $urandom_range(0, 99);
      lo = cfg_year_min;
      hi = cfg_year_max;
      if (r < 60 && lo <= hi) return $urandom_range(lo, hi);
      if (r < 80) begin
         case (r & 3)
            0: return (lo > 0) ? lo - 1 : 0;
            1: return lo;
            2: return hi;
            default: return (hi < 9999) ? hi + 1 : 9999;
         endcase
      end
      return $urandom_range(0, 9999);
   endfunction

   function automatic void gen_stamp(output text_type q);
      int kind;
      q = {};
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 25)) q.push_back(rand_char());
         return;
      end
      push_num(q, pick_year(), 4);
      q.push_back(CHAR_SLASH);
      push_num(q, pick_two(1, 12), 2);
      q.push_back(CHAR_SLASH);
      push_num(q, pick_two(1, 31), 2);
      q.push_back(CHAR_DASH);
      push_num(q, pick_two(0, 23), 2);
      q.push_back(CHAR_COLON);
      push_num(q, pick_two(0, 59), 2);
      q.push_back(CHAR_COLON);
      push_num(q, pick_two(0, 59), 2);
      if (kind >= 80) begin
         if ($urandom_range(0, 1)) q = q[0:$urandom_range(0, 17)];
         else repeat ($urandom_range(1, 6)) q.push_back(rand_char());
      end else if (kind >= 62) begin
         q[$urandom_range(0, 18)] = rand_char();
      end
   endfunction

   task automatic send_char(input char_type c, input logic last);
      int n;
      n = gap_len();
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_stamp(input text_type chars, input bit typed, input result_type want);
      result_type got;
      foreach (chars[i]) begin
         send_char(chars[i], i == chars.size() - 1);
         if (parse_char(chars[i], i == chars.size() - 1, got))
            pending_stamps.push_back(typed ? want : got);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_stamps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [13:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {18'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_YEAR_MIN) cfg_year_min = value;
      else cfg_year_max = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // alternate stretches with and without idling
   initial begin
      forever begin
         calm = 1'b0;
         repeat ($urandom_range(150, 500)) @(posedge clock);
         calm = 1'b1;
         repeat ($urandom_range(30, 150)) @(posedge clock);
      end
   end

   initial begin
      int n;
      forever begin
         n = gap_len();
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{status_type'(rsp_status), rsp_year, rsp_month, rsp_day, rsp_hour,
                 rsp_minute, rsp_second};
         if (pending_stamps.size() == 0) begin
            report_miss({"unexpected transfer ", stamp_str(got)});
         end else begin
            want = pending_stamps.pop_front();
            if (got.status !== want.status || got.year !== want.year ||
                got.month !== want.month || got.day !== want.day ||
                got.hour !== want.hour || got.minute !== want.minute ||
                got.second !== want.second)
               report_miss({"expected ", stamp_str(want), " got ", stamp_str(got)});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[timestamp_text_parser] ERROR");
         $finish;
      end
   end

   initial begin
      text_type    chars;
      logic [13:0] lo;
      logic [13:0] hi;
      rows = '{
         '{"2000/01/01-00:00:00", 1'b1, '{ST_OK, 14'd2000, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0}},
         '{"2050/12/31-23:59:59", 1'b1, '{ST_OK, 14'd2050, 7'd12, 7'd31, 7'd23, 7'd59, 7'd59}},
         '{"1999/12/31-23:59:59", 1'b1, failed(ST_RANGE)},
         '{"2051/01/01-00:00:00", 1'b1, failed(ST_RANGE)},
         '{"2020/00/15-12:30:30", 1'b1, failed(ST_RANGE)},
         '{"2020/13/15-12:30:30", 1'b1, failed(ST_RANGE)},
         '{"2020/06/00-12:30:30", 1'b1, failed(ST_RANGE)},
         '{"2020/06/32-12:30:30", 1'b1, failed(ST_RANGE)},
         '{"2020/06/15-24:30:30", 1'b1, failed(ST_RANGE)},
         '{"2020/06/15-12:60:30", 1'b1, failed(ST_RANGE)},
         '{"2020/06/15-12:30:60", 1'b1, failed(ST_RANGE)},
         '{"2020-06/15-12:30:30", 1'b1, failed(ST_SEP)},
         '{"2020/06/15 12:30:30", 1'b1, failed(ST_SEP)},
         '{"2020/06/15-12.30:30", 1'b1, failed(ST_SEP)},
         '{"2020/06/15-12:30;30", 1'b1, failed(ST_SEP)},
         '{"2020/1x-15-12:30:30", 1'b1, failed(ST_SEP)},
         '{"20x0/13/15-12:30:30", 1'b1, failed(ST_DIGIT)},
         '{"2020/06/15-12:30:3x", 1'b1, failed(ST_DIGIT)},
         '{"2020/99/15-1a:30:30", 1'b1, failed(ST_RANGE)},
         '{"2020/06/15-12:30:3", 1'b1, failed(ST_LEN)},
         '{"2020/06/15-12:30:305", 1'b1, failed(ST_LEN)},
         '{"2020/06/15-12:3a:30xxxxx", 1'b1, failed(ST_LEN)},
         '{"x", 1'b1, failed(ST_LEN)},
         '{"/", 1'b1, failed(ST_LEN)},
         // day is not checked against the month
         '{"2024/02/31-07:45:09", 1'b0, failed(ST_OK)},
         '{"2049/11/30-22:58:01", 1'b0, failed(ST_OK)}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++) begin
         chars = {};
         for (int i = 0; i < rows[r].text.len(); i++) chars.push_back(rows[r].text[i]);
         send_stamp(chars, rows[r].typed, rows[r].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         if (p < 5) begin
            lo = phase_lo[p];
            hi = phase_hi[p];
         end else begin
            lo = 14'($urandom_range(0, 9999));
            hi = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 9999))
                                              : 14'($urandom_range(lo, 9999));
         end
         csr_write(CSR_YEAR_MIN, lo);
         csr_write(CSR_YEAR_MAX, hi);
         repeat (STAMPS_PER_PHASE) begin
            gen_stamp(chars);
            send_stamp(chars, 1'b0, failed(ST_OK));
         end
      end
      drain();

      if (mismatches == 0 && pending_stamps.size() == 0) begin
         $display("[timestamp_text_parser] OK");
      end else begin
         $display("[timestamp_text_parser] ERROR");
      end
      $finish;
   end

endmodule
